// ----- sv/bfe_pkg.sv -----
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants of the bloom filter engine.
// ----------------------------------------------------------------------------
package bfe_pkg;

    localparam int MAX_BYTES  = 8192;
    localparam int MAX_PROBES = 30;
    localparam int MIN_BYTES  = 8;

    localparam int ADDR_W = $clog2(MAX_BYTES);   // byte address
    localparam int POS_W  = ADDR_W + 3;          // bit position
    localparam int BITS_W = ADDR_W + 4;          // filter size in bits
    localparam int EB_W   = ADDR_W + 1;          // effective byte count

    localparam int HASH_W  = 32;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 14;                 // widest register
    localparam int PROBE_W = 5;
    localparam int IDX_W   = 1;

    localparam int NUM_PROBES_RST   = 6;
    localparam int FILTER_BYTES_RST = 8192;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_FILTER_BYTES = 1'd0;
    localparam logic [IDX_W-1:0] REG_NUM_PROBES   = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_CHK,
        ST_CLR,
        ST_DONE
    } t_state;

    // remainders handed from the modulo unit to the probe sequencer
    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] hmod;   // key_hash mod bits
        logic [POS_W-1:0] dmod;   // delta mod bits
        logic [POS_W-1:0] wmod;   // 2^32 mod bits
    } t_mod_res;

endpackage

// ----- sv/bfe_mod.sv -----
// ----------------------------------------------------------------------------
// bfe_mod
// Serial remainder unit: hash, delta and 2^32 modulo the filter size, one
// dividend bit per cycle for all three.
// ----------------------------------------------------------------------------
module bfe_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bfe_pkg::HASH_W-1:0]    i_hash,
    input  logic [bfe_pkg::HASH_W-1:0]    i_delta,
    input  logic [bfe_pkg::BITS_W-1:0]    i_bits,
    output bfe_pkg::t_mod_res             o_res
);
    import bfe_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [HASH_W-1:0] r_dh;
    logic [HASH_W-1:0] r_dd;
    logic [POS_W-1:0]  r_rh;
    logic [POS_W-1:0]  r_rd;
    logic [POS_W-1:0]  r_rw;

    // one restoring step; r < bits on entry, so one subtract is enough
    function automatic logic [POS_W-1:0] mod_step(input logic [POS_W-1:0] r,
                                                  input logic din,
                                                  input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] t;
        logic [BITS_W-1:0] d;
        t = {r, din};
        d = t - bits;
        return (t >= bits) ? d[POS_W-1:0] : t[POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dh <= i_hash;
            r_dd <= i_delta;
            r_rh <= '0;
            r_rd <= '0;
            r_rw <= POS_W'(1);   // leading one of 2^32
        end else if (r_busy) begin
            r_dh <= {r_dh[HASH_W-2:0], 1'b0};
            r_dd <= {r_dd[HASH_W-2:0], 1'b0};
            r_rh <= mod_step(r_rh, r_dh[HASH_W-1], i_bits);
            r_rd <= mod_step(r_rd, r_dd[HASH_W-1], i_bits);
            r_rw <= mod_step(r_rw, 1'b0, i_bits);
        end
    end

    assign o_res.done = r_done;
    assign o_res.hmod = r_rh;
    assign o_res.dmod = r_rd;
    assign o_res.wmod = r_rw;

endmodule

// ----- sv/bloom_filter_engine_top.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_engine_top
// Bloom filter over an on-chip byte store, double-hashed probes.
//
//  channel   dir  handshake                 payload
//  s (key)   in   i_s_tvalid / o_s_tready   tuser: op, tdata: key_hash
//  m (resp)  out  o_m_tvalid / i_m_tready   tdata: may_match
//  cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Insert/query: the serial modulo unit first, then per probe a store read
// followed by a test or read-modify-write.
// A query stops at the first clear bit. Clear: one byte per cycle over the
// bytes in use. Reset: the store is wiped, all MAX_BYTES bytes, no word taken.
// A finished response waits in the output register; the next word is taken
// meanwhile and held only if that register is still full when it finishes.
// ----------------------------------------------------------------------------
module bloom_filter_engine_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // key words
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,   // [31:0] key_hash
    input  logic [1:0]                    i_s_tuser,   // [1:0] op
    // response words
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,   // [0] may_match
    // config
    input  logic                          i_cfg_we,
    input  logic [bfe_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [bfe_pkg::CFG_W-1:0]     i_cfg_data
);
    import bfe_pkg::*;

    // config
    logic [CFG_W-1:0]   r_filter_bytes;
    logic [PROBE_W-1:0] r_num_probes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bytes <= CFG_W'(FILTER_BYTES_RST);
            r_num_probes   <= PROBE_W'(NUM_PROBES_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FILTER_BYTES: r_filter_bytes <= i_cfg_data;
                REG_NUM_PROBES:   r_num_probes   <= i_cfg_data[PROBE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [EB_W-1:0]    eff_bytes;
    logic [EB_W-1:0]    eff_m1;
    logic [PROBE_W-1:0] eff_klast;

    always_comb begin
        if (r_filter_bytes < CFG_W'(MIN_BYTES)) begin
            eff_bytes = EB_W'(MIN_BYTES);
        end else if (32'(r_filter_bytes) > 32'(MAX_BYTES)) begin
            eff_bytes = EB_W'(MAX_BYTES);
        end else begin
            eff_bytes = EB_W'(r_filter_bytes);
        end
        eff_m1 = eff_bytes - 1'b1;
        if (r_num_probes == '0) begin
            eff_klast = '0;
        end else if (r_num_probes > PROBE_W'(MAX_PROBES)) begin
            eff_klast = PROBE_W'(MAX_PROBES - 1);
        end else begin
            eff_klast = r_num_probes - 1'b1;
        end
    end

    // state
    t_state             r_state,  n_state;
    t_op                r_op,     n_op;
    logic [HASH_W-1:0]  r_h,      n_h;
    logic [HASH_W-1:0]  r_delta,  n_delta;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [POS_W-1:0]   r_dmod,   n_dmod;
    logic [POS_W-1:0]   r_wmod,   n_wmod;
    logic [BITS_W-1:0]  r_bits,   n_bits;
    logic [PROBE_W-1:0] r_probe,  n_probe;
    logic [PROBE_W-1:0] r_klast,  n_klast;
    logic [ADDR_W-1:0]  r_addr,   n_addr;
    logic [ADDR_W-1:0]  r_last,   n_last;
    logic               r_match,  n_match;
    logic               r_ovalid, n_ovalid;
    logic               r_omatch, n_omatch;

    logic               mod_start;
    t_mod_res           mod_res;

    // store
    logic [7:0]         r_mem [MAX_BYTES];
    logic [7:0]         r_rdata;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_pos[POS_W-1:3]];
    end

    bfe_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_hash  (r_h),
        .i_delta (r_delta),
        .i_bits  (r_bits),
        .o_res   (mod_res)
    );

    // next probe position: (pos + delta - carry*2^32) mod bits
    logic [HASH_W:0]   hsum;
    logic [BITS_W-1:0] psum;
    logic [BITS_W-1:0] pred;
    logic [BITS_W-1:0] pnext;
    logic [7:0]        bmask;

    always_comb begin
        hsum = {1'b0, r_h} + {1'b0, r_delta};
        psum = {1'b0, r_pos} + {1'b0, r_dmod};
        pred = (psum >= r_bits) ? psum - r_bits : psum;
        if (!hsum[HASH_W]) begin
            pnext = pred;
        end else if (pred >= {1'b0, r_wmod}) begin
            pnext = pred - {1'b0, r_wmod};
        end else begin
            pnext = pred + r_bits - {1'b0, r_wmod};
        end
        bmask = 8'(1) << r_pos[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_WIPE;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_h      <= n_h;
        r_delta  <= n_delta;
        r_pos    <= n_pos;
        r_dmod   <= n_dmod;
        r_wmod   <= n_wmod;
        r_bits   <= n_bits;
        r_probe  <= n_probe;
        r_klast  <= n_klast;
        r_last   <= n_last;
        r_match  <= n_match;
        r_omatch <= n_omatch;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_h       = r_h;
        n_delta   = r_delta;
        n_pos     = r_pos;
        n_dmod    = r_dmod;
        n_wmod    = r_wmod;
        n_bits    = r_bits;
        n_probe   = r_probe;
        n_klast   = r_klast;
        n_addr    = r_addr;
        n_last    = r_last;
        n_match   = r_match;
        n_ovalid  = r_ovalid & ~i_m_tready;
        n_omatch  = r_omatch;
        o_s_tready = 1'b0;
        mod_start = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;

        case (r_state)
            ST_WIPE: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_W'(MAX_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_op    = t_op'(i_s_tuser);
                    n_h     = i_s_tdata;
                    n_delta = {i_s_tdata[16:0], i_s_tdata[31:17]};
                    n_bits  = {eff_bytes, 3'b000};
                    n_klast = eff_klast;
                    n_probe = '0;
                    n_match = 1'b0;
                    n_addr  = '0;
                    n_last  = eff_m1[ADDR_W-1:0];
                    case (t_op'(i_s_tuser))
                        OP_INSERT, OP_QUERY: n_state = ST_MOD;
                        OP_CLEAR:            n_state = ST_CLR;
                        default:             n_state = ST_DONE;
                    endcase
                end
            end
            ST_MOD: begin
                // start pulses on entry, the unit is idle otherwise
                mod_start = (r_probe == '0) && !mod_res.done;
                n_probe   = PROBE_W'(1);
                if (mod_res.done) begin
                    n_pos   = mod_res.hmod;
                    n_dmod  = mod_res.dmod;
                    n_wmod  = mod_res.wmod;
                    n_probe = '0;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_pos   = pnext[POS_W-1:0];
                n_h     = hsum[HASH_W-1:0];
                n_probe = r_probe + 1'b1;
                n_state = ST_RD;
                if (r_op == OP_INSERT) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[POS_W-1:3];
                    mem_wdata = r_rdata | bmask;
                end
                if (r_op == OP_QUERY && (r_rdata & bmask) == 8'd0) begin
                    n_match = 1'b0;
                    n_state = ST_DONE;
                end else if (r_probe == r_klast) begin
                    n_match = (r_op == OP_QUERY);
                    n_state = ST_DONE;
                end
            end
            ST_CLR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == r_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_omatch = r_match;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_omatch};

endmodule
